// ===== hw/rtl/fifo_with_running_max_unit_macros.svh =====
// ----------------------------------------------------------------------------
// fifo_with_running_max_unit macros
// assertion helpers clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_RUNNING_MAX_UNIT_MACROS_SVH
`define FIFO_WITH_RUNNING_MAX_UNIT_MACROS_SVH

// condition holds at every edge
`define FWRM_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FWRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/fwrm_pkg.sv =====
// ----------------------------------------------------------------------------
// fwrm_pkg
// shared types and codes of the running maximum fifo
// ----------------------------------------------------------------------------
package fwrm_pkg;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/fwrm_if.sv =====
// ----------------------------------------------------------------------------
// fwrm_if
// valid/ready channels for operations and results
// ----------------------------------------------------------------------------
interface fwrm_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

interface fwrm_out_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_WIDTH   = 5
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] max_value;
  logic                          max_valid;
  logic [1:0]                    status;
  logic [CNT_WIDTH-1:0]          occupancy;

  modport source (output valid, output max_value, output max_valid, output status,
                  output occupancy, input ready);
  modport sink (input valid, input max_value, input max_valid, input status,
                input occupancy, output ready);
endinterface

// ===== hw/rtl/fwrm_tag_cell.sv =====
// ----------------------------------------------------------------------------
// fwrm_tag_cell
// one entry slot of the fifo row, holds the sequence tag of its entry
// ----------------------------------------------------------------------------
module fwrm_tag_cell #(
  parameter int TAG_W = 4
) (
  input  logic                clk_i,
  input  fwrm_pkg::cell_ctrl_t ctrl_i,
  input  logic [TAG_W-1:0]    tag_i,
  input  logic [TAG_W-1:0]    next_tag_i,
  output logic [TAG_W-1:0]    tag_o
);
  import fwrm_pkg::*;

  logic [TAG_W-1:0] tag_q, tag_d;

  always_comb begin
    tag_d = tag_q;
    if (ctrl_i.shift) begin
      tag_d = next_tag_i;
    end else if (ctrl_i.load) begin
      tag_d = tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
  end

  assign tag_o = tag_q;

endmodule

// ===== hw/rtl/fwrm_cand_cell.sv =====
// ----------------------------------------------------------------------------
// fwrm_cand_cell
// one slot of the monotonic candidate row, compares against the pushed value
// ----------------------------------------------------------------------------
module fwrm_cand_cell #(
  parameter int VALUE_WIDTH = 32,
  parameter int TAG_W       = 4
) (
  input  logic                          clk_i,
  input  fwrm_pkg::cell_ctrl_t          ctrl_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic [TAG_W-1:0]              tag_i,
  input  logic signed [VALUE_WIDTH-1:0] next_value_i,
  input  logic [TAG_W-1:0]              next_tag_i,
  output logic signed [VALUE_WIDTH-1:0] value_o,
  output logic [TAG_W-1:0]              tag_o,
  output logic                          gt_o
);
  import fwrm_pkg::*;

  logic signed [VALUE_WIDTH-1:0] value_q, value_d;
  logic [TAG_W-1:0]              tag_q, tag_d;

  always_comb begin
    value_d = value_q;
    tag_d   = tag_q;
    if (ctrl_i.shift) begin
      value_d = next_value_i;
      tag_d   = next_tag_i;
    end else if (ctrl_i.load) begin
      value_d = value_i;
      tag_d   = tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    tag_q   <= tag_d;
  end

  // survives a push only when strictly greater than the new value
  assign gt_o    = value_q > value_i;
  assign value_o = value_q;
  assign tag_o   = tag_q;

endmodule

// ===== hw/rtl/fifo_with_running_max_unit.sv =====
// one operation per transaction; its result is registered and shown the cycle after
// a new transaction is taken in the same cycle the previous result is taken
// sustained rate one transaction per cycle while the result side is ready
// the fifo and candidate rows are cell chains, a pop shifts the fifo row and,
// when its head leaves, the candidate row in the same cycle
// reset empties the queue and clears tag and counters; slot contents stay unset
// ----------------------------------------------------------------------------
// fifo_with_running_max_unit
// fifo of signed values that reports the maximum it currently holds
// ----------------------------------------------------------------------------
module fifo_with_running_max_unit #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fwrm_in_if.sink    in_i,
  fwrm_out_if.source out_o
);
  import fwrm_pkg::*;

  localparam int TAG_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
  localparam logic [TAG_W-1:0] TAG_LAST  = TAG_W'(DEPTH - 1);

  logic [CNT_W-1:0] entry_cnt_q, entry_cnt_d;
  logic [CNT_W-1:0] cand_cnt_q, cand_cnt_d;
  logic [TAG_W-1:0] next_tag_q, next_tag_d;
  logic [1:0]       status_q, status_d;
  logic             out_valid_q;

  logic in_fire, do_push, do_pop, drop_head, push_on_full;

  cell_ctrl_t ent_ctrl [DEPTH];
  cell_ctrl_t cand_ctrl [DEPTH];
  logic [TAG_W-1:0]              ent_tag [DEPTH];
  logic [TAG_W-1:0]              ent_nxt_tag [DEPTH];
  logic signed [VALUE_WIDTH-1:0] cand_val [DEPTH];
  logic signed [VALUE_WIDTH-1:0] cand_nxt_val [DEPTH];
  logic [TAG_W-1:0]              cand_tag [DEPTH];
  logic [TAG_W-1:0]              cand_nxt_tag [DEPTH];
  logic [DEPTH-1:0]              cand_gt, cand_keep, cand_load;
  logic [CNT_W-1:0]              push_cnt;

  assign in_i.ready   = !out_valid_q || out_o.ready;
  assign in_fire      = in_i.valid && in_i.ready;
  assign do_push      = in_fire && (in_i.command == CMD_PUSH) && (entry_cnt_q != DEPTH_C);
  assign do_pop       = in_fire && (in_i.command == CMD_POP) && (entry_cnt_q != '0);
  assign push_on_full = in_fire && (in_i.command == CMD_PUSH) && (entry_cnt_q == DEPTH_C);
  assign drop_head    = (cand_cnt_q != '0) && (ent_tag[0] == cand_tag[0]);

  for (genvar i = 0; i < DEPTH; i++) begin : g_row
    if (i == DEPTH - 1) begin : g_last
      assign ent_nxt_tag[i]  = ent_tag[i];
      assign cand_nxt_val[i] = cand_val[i];
      assign cand_nxt_tag[i] = cand_tag[i];
    end else begin : g_mid
      assign ent_nxt_tag[i]  = ent_tag[i+1];
      assign cand_nxt_val[i] = cand_val[i+1];
      assign cand_nxt_tag[i] = cand_tag[i+1];
    end

    if (i == 0) begin : g_first
      assign cand_load[i] = do_push && !cand_keep[i];
    end else begin : g_rest
      assign cand_load[i] = do_push && cand_keep[i-1] && !cand_keep[i];
    end

    assign cand_keep[i]    = (CNT_W'(i) < cand_cnt_q) && cand_gt[i];
    assign ent_ctrl[i]     = '{shift: do_pop, load: do_push && (entry_cnt_q == CNT_W'(i))};
    assign cand_ctrl[i]    = '{shift: do_pop && drop_head, load: cand_load[i]};

    fwrm_tag_cell #(
      .TAG_W (TAG_W)
    ) u_ent (
      .clk_i      (clk_i),
      .ctrl_i     (ent_ctrl[i]),
      .tag_i      (next_tag_q),
      .next_tag_i (ent_nxt_tag[i]),
      .tag_o      (ent_tag[i])
    );

    fwrm_cand_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .TAG_W       (TAG_W)
    ) u_cand (
      .clk_i        (clk_i),
      .ctrl_i       (cand_ctrl[i]),
      .value_i      (in_i.value),
      .tag_i        (next_tag_q),
      .next_value_i (cand_nxt_val[i]),
      .next_tag_i   (cand_nxt_tag[i]),
      .value_o      (cand_val[i]),
      .tag_o        (cand_tag[i]),
      .gt_o         (cand_gt[i])
    );
  end

  // new candidate count is one past the single loading slot
  always_comb begin
    push_cnt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      push_cnt = push_cnt | (cand_load[i] ? CNT_W'(i + 1) : '0);
    end
  end

  always_comb begin
    entry_cnt_d = entry_cnt_q;
    cand_cnt_d  = cand_cnt_q;
    next_tag_d  = next_tag_q;
    status_d    = status_q;
    if (in_fire) begin
      status_d = ST_OK;
      if (in_i.command == CMD_PUSH) begin
        if (do_push) begin
          entry_cnt_d = entry_cnt_q + 1'b1;
          cand_cnt_d  = push_cnt;
          next_tag_d  = (next_tag_q == TAG_LAST) ? '0 : next_tag_q + 1'b1;
        end else begin
          status_d = ST_FULL;
        end
      end else begin
        if (do_pop) begin
          entry_cnt_d = entry_cnt_q - 1'b1;
          if (drop_head) begin
            cand_cnt_d = cand_cnt_q - 1'b1;
          end
        end else begin
          status_d = ST_EMPTY;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_cnt_q <= '0;
      cand_cnt_q  <= '0;
      next_tag_q  <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      entry_cnt_q <= entry_cnt_d;
      cand_cnt_q  <= cand_cnt_d;
      next_tag_q  <= next_tag_d;
      status_q    <= status_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.max_valid = (entry_cnt_q != '0) && (cand_cnt_q != '0);
  assign out_o.max_value = out_o.max_valid ? cand_val[0] : '0;
  assign out_o.status    = status_q;
  assign out_o.occupancy = entry_cnt_q;

  `include "fifo_with_running_max_unit_macros.svh"

  `FWRM_ASSERT(a_cand_le_entry, cand_cnt_q <= entry_cnt_q, "candidates exceed entries")
  `FWRM_ASSERT(a_cand_nonempty, (entry_cnt_q != '0) == (cand_cnt_q != '0), "candidate count off")
  `FWRM_ASSERT(a_depth_bound, entry_cnt_q <= DEPTH_C, "occupancy above depth")
  `FWRM_ASSERT_NEXT(a_full, push_on_full, out_valid_q && (status_q == ST_FULL), "full push missed")

endmodule

// ===== tb/sv/fifo_with_running_max_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_with_running_max_unit_tb
// Drives push and pop transactions into the running maximum fifo with random
// gaps and result-side stalls. An in-bench model of the queue and its
// monotonic candidate list predicts every result, and each returned result
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fifo_with_running_max_unit_tb;
  import fwrm_pkg::*;

  localparam int DEPTH = 16;
  localparam int VW    = 32;
  localparam int CW    = 5;

  typedef struct {
    logic                 cmd;
    logic signed [VW-1:0] val;
    int unsigned          gap;
    bit                   drain;
  } fifo_op_t;

  typedef struct {
    logic signed [VW-1:0] max_value;
    logic                 max_valid;
    logic [1:0]           status;
    logic [CW-1:0]        occupancy;
  } max_report_t;

  logic clk_i;
  logic rst_ni;

  fwrm_in_if  #(.VALUE_WIDTH(VW))                op_if ();
  fwrm_out_if #(.VALUE_WIDTH(VW), .CNT_WIDTH(CW)) res_if ();

  fifo_with_running_max_unit #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VW)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (op_if),
    .out_o (res_if)
  );

  fifo_op_t             pending_ops[$];
  max_report_t          expected_max_reports[$];

  // in-bench copy of the queue contents and the candidate list
  logic signed [VW-1:0] held_values[$];
  logic [3:0]           held_tags[$];
  logic signed [VW-1:0] cand_values[$];
  logic [3:0]           cand_tags[$];
  logic [3:0]           tag_ctr;

  int unsigned          errors;
  int unsigned          rcv_hold;
  bit                   rcv_quiet;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic predict_running_max(input logic cmd, input logic signed [VW-1:0] val);
    max_report_t r;
    r.status = ST_OK;
    if (cmd == CMD_PUSH) begin
      if (held_values.size() >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        while (cand_values.size() > 0 && cand_values[$] <= val) begin
          cand_values.delete(cand_values.size() - 1);
          cand_tags.delete(cand_tags.size() - 1);
        end
        cand_values.insert(cand_values.size(), val);
        cand_tags.insert(cand_tags.size(), tag_ctr);
        held_values.insert(held_values.size(), val);
        held_tags.insert(held_tags.size(), tag_ctr);
        tag_ctr = tag_ctr + 4'd1;
      end
    end else begin
      if (held_values.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        if (cand_values.size() > 0 && held_tags[0] == cand_tags[0]) begin
          cand_values.delete(0);
          cand_tags.delete(0);
        end
        held_values.delete(0);
        held_tags.delete(0);
      end
    end
    if (held_values.size() > 0 && cand_values.size() > 0) begin
      r.max_value = cand_values[0];
      r.max_valid = 1'b1;
    end else begin
      r.max_value = '0;
      r.max_valid = 1'b0;
    end
    r.occupancy = CW'(held_values.size());
    expected_max_reports.insert(expected_max_reports.size(), r);
  endtask

  task automatic check_result();
    max_report_t e;
    if (expected_max_reports.size() == 0) begin
      report_mismatch("result with no transaction outstanding");
    end else begin
      e = expected_max_reports[0];
      expected_max_reports.delete(0);
      if (res_if.max_value !== e.max_value)
        report_mismatch($sformatf("max_value %0d, expected %0d", res_if.max_value,
                                  e.max_value));
      if (res_if.max_valid !== e.max_valid)
        report_mismatch($sformatf("max_valid %b, expected %b", res_if.max_valid,
                                  e.max_valid));
      if (res_if.status !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", res_if.status, e.status));
      if (res_if.occupancy !== e.occupancy)
        report_mismatch($sformatf("occupancy %0d, expected %0d", res_if.occupancy,
                                  e.occupancy));
    end
  endtask

  function automatic logic signed [VW-1:0] draw_value();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return {1'b1, {(VW-1){1'b0}}};
    if (pick == 1) return {1'b0, {(VW-1){1'b1}}};
    if (pick < 8) return $signed($urandom_range(0, 8)) - 4;
    return $urandom();
  endfunction

  task automatic add_op(input logic cmd, input logic signed [VW-1:0] val,
                        input int unsigned gap, input bit drain);
    fifo_op_t op;
    op.cmd   = cmd;
    op.val   = val;
    op.gap   = gap;
    op.drain = drain;
    pending_ops.insert(pending_ops.size(), op);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_if.valid   <= 1'b0;
      op_if.command <= CMD_PUSH;
      op_if.value   <= '0;
    end else begin
      if (op_if.valid && op_if.ready) begin
        predict_running_max(op_if.command, op_if.value);
      end
      if (!op_if.valid || op_if.ready) begin
        if (pending_ops.size() == 0) begin
          op_if.valid <= 1'b0;
        end else if (pending_ops[0].gap > 0) begin
          pending_ops[0].gap = pending_ops[0].gap - 1;
          op_if.valid <= 1'b0;
        end else if (pending_ops[0].drain && expected_max_reports.size() != 0) begin
          op_if.valid <= 1'b0;
        end else begin
          op_if.valid   <= 1'b1;
          op_if.command <= pending_ops[0].cmd;
          op_if.value   <= pending_ops[0].val;
          pending_ops.delete(0);
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rcv_hold = 0;
      rcv_quiet = 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        check_result();
        if ($urandom_range(0, 63) == 0) rcv_quiet = !rcv_quiet;
        rcv_hold = rcv_quiet ? 0 : $urandom_range(0, 9);
      end
      if (rcv_hold > 0) begin
        rcv_hold--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned seg_len;
    int unsigned push_pct;
    bit          quiet;
    logic        cmd;

    errors     = 0;
    tag_ctr    = 4'd0;
    rst_ni     = 1'b0;

    // pop on empty, extremes, equal values, fill to full, push on full
    add_op(CMD_POP,  draw_value(),               $urandom_range(0, 9), 1'b0);
    add_op(CMD_PUSH, {1'b1, {(VW-1){1'b0}}},     0, 1'b0);
    add_op(CMD_PUSH, {1'b0, {(VW-1){1'b1}}},     0, 1'b0);
    add_op(CMD_PUSH, {1'b0, {(VW-1){1'b1}}},     $urandom_range(0, 9), 1'b0);
    add_op(CMD_PUSH, -1,                         0, 1'b0);
    add_op(CMD_PUSH, 0,                          0, 1'b0);
    add_op(CMD_PUSH, 0,                          $urandom_range(0, 9), 1'b0);
    add_op(CMD_PUSH, {1'b1, {(VW-1){1'b0}}},     0, 1'b0);
    add_op(CMD_PUSH, 100,                        0, 1'b0);
    add_op(CMD_PUSH, 50,                         0, 1'b0);
    add_op(CMD_PUSH, 50,                         $urandom_range(0, 9), 1'b0);
    add_op(CMD_PUSH, -5,                         0, 1'b0);
    add_op(CMD_PUSH, 7,                          0, 1'b0);
    add_op(CMD_PUSH, -100,                       0, 1'b0);
    add_op(CMD_PUSH, 1,                          0, 1'b0);
    add_op(CMD_PUSH, 2,                          $urandom_range(0, 9), 1'b0);
    add_op(CMD_PUSH, 3,                          0, 1'b0);
    add_op(CMD_PUSH, 1,                          0, 1'b0);
    for (int i = 0; i < 6; i++) begin
      add_op(CMD_POP, draw_value(), (i < 3) ? 0 : $urandom_range(0, 9), i == 5);
    end

    // random traffic in segments that lean toward filling or draining, or are balanced
    while (pending_ops.size() < 1550) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 15;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < seg_len && pending_ops.size() < 1550; i++) begin
        cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        add_op(cmd, draw_value(), quiet ? 0 : $urandom_range(0, 9),
               $urandom_range(0, 99) == 0);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    #1;
    while (pending_ops.size() != 0 || op_if.valid || expected_max_reports.size() != 0) begin
      @(posedge clk_i);
      #1;
    end
    repeat (10) @(posedge clk_i);

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
